@@ rtl/dtpd_pkg.sv @@
// Shared constants, types and bit-interleave function for the DDR tap pixel deinterleaver.
package dtpd_pkg;

   localparam int MAX_ROWS  = 2048;
   localparam int MAX_COLS  = 2048;
   localparam int MIN_ROWS  = 2;
   localparam int MIN_COLS  = 4;
   localparam int BYTE_W    = 8;
   localparam int PIX_W     = 2 * BYTE_W;
   localparam int ADDR_W    = 22;
   localparam int SIZE_W    = 12;
   localparam int CNT_W     = 11;
   localparam int QTR_W     = SIZE_W - 2;
   localparam int SLOTS     = 4;
   localparam int SLOT_W    = 2;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_W     = SIZE_W;
   localparam int REGION_W  = 3;

   localparam logic [SIZE_W-1:0] ROWS_RESET = SIZE_W'(1024);
   localparam logic [SIZE_W-1:0] COLS_RESET = SIZE_W'(1280);

   localparam logic [REGION_W-1:0] REGION_OF_SLOT [SLOTS] = '{3'd2, 3'd1, 3'd4, 3'd3};

   typedef enum logic [1:0] {
      MODE_BLOCK_2X2   = 2'd0,
      MODE_TWO_ROW     = 2'd1,
      MODE_FOUR_REGION = 2'd2,
      MODE_OFF         = 2'd3
   } tap_mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TAP_MODE   = 2'd0,
      CSR_FRAME_ROWS = 2'd1,
      CSR_FRAME_COLS = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [SLOTS-1:0][PIX_W-1:0] pix;
      logic [CNT_W-1:0]            row;
      logic [CNT_W-1:0]            col;
      tap_mode_type                mode;
      logic [SIZE_W-1:0]           cols;
      logic [QTR_W-1:0]            quarter;
      logic                        frame_end;
   } dtpd_item_type;

   function automatic logic [PIX_W-1:0] interleave(input logic [BYTE_W-1:0] ev,
                                                  input logic [BYTE_W-1:0] od);
      logic [PIX_W-1:0] px;
      px = '0;
      for (int i = 0; i < BYTE_W; i++) begin
         px[2*i]   = ev[i];
         px[2*i+1] = od[i];
      end
      return px;
   endfunction

endpackage

@@ rtl/dtpd_req_if.sv @@
// Input channel: one DDR transfer group of four even/odd byte pairs per beat.
interface dtpd_req_if import dtpd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] even_byte0;
   logic [BYTE_W-1:0] even_byte1;
   logic [BYTE_W-1:0] even_byte2;
   logic [BYTE_W-1:0] even_byte3;
   logic [BYTE_W-1:0] odd_byte0;
   logic [BYTE_W-1:0] odd_byte1;
   logic [BYTE_W-1:0] odd_byte2;
   logic [BYTE_W-1:0] odd_byte3;

   modport source (
      output valid, even_byte0, even_byte1, even_byte2, even_byte3,
      output odd_byte0, odd_byte1, odd_byte2, odd_byte3,
      input  ready
   );

   modport sink (
      input  valid, even_byte0, even_byte1, even_byte2, even_byte3,
      input  odd_byte0, odd_byte1, odd_byte2, odd_byte3,
      output ready
   );
endinterface

@@ rtl/dtpd_rsp_if.sv @@
// Result channel: one addressed pixel per beat.
interface dtpd_rsp_if import dtpd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [PIX_W-1:0]  pixel_value;
   logic [ADDR_W-1:0] pixel_address;
   logic              last_of_group;
   logic              frame_end;

   modport source (
      output valid, pixel_value, pixel_address, last_of_group, frame_end,
      input  ready
   );

   modport sink (
      input  valid, pixel_value, pixel_address, last_of_group, frame_end,
      output ready
   );
endinterface

@@ rtl/ddr_tap_pixel_deinterleave_core.sv @@
// DDR tap pixel deinterleaver: rebuilds 16-bit pixels and places them in the frame.
//
// req_bus carries one DDR transfer group per beat (four even/odd byte pairs).
// rsp_bus returns one pixel per beat with its linear frame address; last_of_group
// marks the final pixel of a group and frame_end the final pixel of the frame.
// csr_write_en/csr_index/csr_wdata write tap_mode (0), frame_rows (1) and
// frame_cols (2); write them only while the block is empty.
// A group passes the input register, the group buffer and the result register.
// Pixels leave one per cycle, while rsp_bus is ready, through the single result
// register: four per group in the 2x2 and four-region modes, two in two-row mode;
// groups follow back to back with no gap. In the off mode groups are taken and
// dropped at one per cycle and the position counters hold.
// Reset clears the row and column counters, empties every stage and loads the
// default mode (2x2), 1024 rows and 1280 columns.
// A stalled rsp_bus holds the current pixel; the group buffer and the input
// register behind it fill, then req_bus.ready drops until the stall clears.
module ddr_tap_pixel_deinterleave_core import dtpd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   dtpd_req_if.sink             req_bus,
   dtpd_rsp_if.source           rsp_bus,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);
   localparam logic [SLOT_W-1:0] PAIR_LAST = SLOT_W'(1);

   tap_mode_type      mode_ff, mode_in;
   logic [SIZE_W-1:0] rows_ff, rows_in;
   logic [SIZE_W-1:0] cols_ff, cols_in;
   logic [CNT_W-1:0]  row_ff, row_in;
   logic [CNT_W-1:0]  col_ff, col_in;

   dtpd_item_type     s1_ff, s1_in;
   logic              s1_valid_ff, s1_valid_in;

   logic [PIX_W-1:0]  grp_pix_ff [SLOTS];
   logic [PIX_W-1:0]  grp_pix_in [SLOTS];
   logic [ADDR_W-1:0] grp_addr_ff [SLOTS];
   logic [ADDR_W-1:0] grp_addr_in [SLOTS];
   logic [SLOT_W-1:0] grp_last_ff, grp_last_in;
   logic [SLOT_W-1:0] grp_idx_ff, grp_idx_in;
   logic              grp_fe_ff, grp_fe_in;
   logic              grp_valid_ff, grp_valid_in;

   logic [PIX_W-1:0]  rsp_pix_ff, rsp_pix_in;
   logic [ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_fe_ff, rsp_fe_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic              req_fire;
   logic              out_load;
   logic              grp_at_last;
   logic              grp_free;
   logic              s1_move;

   logic [SIZE_W-1:0] rows_cl, cols_cl;
   logic [SIZE_W-1:0] rows_lim, col_lim;
   logic [SIZE_W-1:0] r_ext, c_ext, r_one, c_one;
   logic [SIZE_W-1:0] r_eff, c_eff, r_step, c_step;
   logic [SIZE_W-1:0] col_inc, row_inc;
   logic              fit;
   logic              wrap_fe;
   logic [SIZE_W-1:0] r_next, c_next;

   logic [CNT_W+SIZE_W-1:0] prod;
   logic [ADDR_W-1:0]       base;
   logic [SIZE_W:0]         off [SLOTS];
   logic [SIZE_W-1:0]       reg_col;

   // handshake
   assign req_fire    = req_bus.valid && req_bus.ready;
   assign out_load    = !rsp_valid_ff || rsp_bus.ready;
   assign grp_at_last = grp_idx_ff == grp_last_ff;
   assign grp_free    = !grp_valid_ff || (out_load && grp_at_last);
   assign s1_move     = s1_valid_ff && grp_free;
   assign req_bus.ready = !s1_valid_ff || s1_move;

   // configuration
   always_comb begin
      mode_in = mode_ff;
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_TAP_MODE:   mode_in = tap_mode_type'(csr_wdata[1:0]);
            CSR_FRAME_ROWS: rows_in = csr_wdata;
            CSR_FRAME_COLS: cols_in = csr_wdata;
            default:        mode_in = mode_ff;
         endcase
      end
   end

   // geometry and position advance
   always_comb begin
      rows_cl = (rows_ff < SIZE_W'(MIN_ROWS)) ? SIZE_W'(MIN_ROWS) :
                (rows_ff > SIZE_W'(MAX_ROWS)) ? SIZE_W'(MAX_ROWS) : rows_ff;
      cols_cl = (cols_ff < SIZE_W'(MIN_COLS)) ? SIZE_W'(MIN_COLS) :
                (cols_ff > SIZE_W'(MAX_COLS)) ? SIZE_W'(MAX_COLS) : cols_ff;
      r_ext = {1'b0, row_ff};
      c_ext = {1'b0, col_ff};
      r_one = r_ext + SIZE_W'(1);
      c_one = c_ext + SIZE_W'(1);
      case (mode_ff)
         MODE_BLOCK_2X2: begin
            rows_lim = {rows_cl[SIZE_W-1:1], 1'b0};
            col_lim  = {cols_cl[SIZE_W-1:1], 1'b0};
            col_inc  = SIZE_W'(2);
            row_inc  = SIZE_W'(2);
            fit      = (r_one < rows_lim) && (c_one < col_lim);
         end
         MODE_TWO_ROW: begin
            rows_lim = {rows_cl[SIZE_W-1:1], 1'b0};
            col_lim  = cols_cl;
            col_inc  = SIZE_W'(1);
            row_inc  = SIZE_W'(2);
            fit      = (r_one < rows_lim) && (c_ext < col_lim);
         end
         default: begin
            rows_lim = rows_cl;
            col_lim  = {2'b00, cols_cl[SIZE_W-1:2]};
            col_inc  = SIZE_W'(1);
            row_inc  = SIZE_W'(1);
            fit      = (r_ext < rows_lim) && (c_ext < col_lim);
         end
      endcase
      r_eff   = fit ? r_ext : '0;
      c_eff   = fit ? c_ext : '0;
      c_step  = c_eff + col_inc;
      r_step  = r_eff + row_inc;
      wrap_fe = 1'b0;
      r_next  = r_eff;
      c_next  = c_step;
      if (c_step >= col_lim) begin
         c_next = '0;
         r_next = r_step;
         if (r_step >= rows_lim) begin
            r_next  = '0;
            wrap_fe = 1'b1;
         end
      end
   end

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (req_fire && mode_ff != MODE_OFF) begin
         row_in = r_next[CNT_W-1:0];
         col_in = c_next[CNT_W-1:0];
      end
   end

   // input register
   always_comb begin
      s1_in       = s1_ff;
      s1_valid_in = s1_move ? 1'b0 : s1_valid_ff;
      if (req_fire && mode_ff != MODE_OFF) begin
         s1_valid_in      = 1'b1;
         s1_in.pix[0]     = interleave(req_bus.even_byte0, req_bus.odd_byte0);
         s1_in.pix[1]     = interleave(req_bus.even_byte1, req_bus.odd_byte1);
         s1_in.pix[2]     = interleave(req_bus.even_byte2, req_bus.odd_byte2);
         s1_in.pix[3]     = interleave(req_bus.even_byte3, req_bus.odd_byte3);
         s1_in.row        = r_eff[CNT_W-1:0];
         s1_in.col        = c_eff[CNT_W-1:0];
         s1_in.mode       = mode_ff;
         s1_in.cols       = cols_cl;
         s1_in.quarter    = col_lim[QTR_W-1:0];
         s1_in.frame_end  = wrap_fe;
      end
   end

   // group buffer: addresses and slot order
   always_comb begin
      prod = s1_ff.row * s1_ff.cols;
      base = prod[ADDR_W-1:0];
      grp_last_in = (s1_ff.mode == MODE_TWO_ROW) ? PAIR_LAST : LAST_SLOT;
      grp_fe_in   = s1_ff.frame_end;
      reg_col     = '0;
      for (int s = 0; s < SLOTS; s++) begin
         off[s]         = '0;
         grp_pix_in[s]  = s1_ff.pix[s];
      end
      if (s1_ff.mode == MODE_FOUR_REGION) begin
         for (int s = 0; s < SLOTS; s++) begin
            reg_col = SIZE_W'({2'b00, s1_ff.quarter} * SIZE_W'(REGION_OF_SLOT[s]))
                      - {1'b0, s1_ff.col} - SIZE_W'(1);
            off[s]  = {1'b0, reg_col};
         end
      end else begin
         grp_pix_in[0] = s1_ff.pix[1];
         grp_pix_in[1] = s1_ff.pix[0];
         grp_pix_in[2] = s1_ff.pix[3];
         grp_pix_in[3] = s1_ff.pix[2];
         off[0] = {2'b00, s1_ff.col};
         off[1] = {1'b0, s1_ff.cols} + {2'b00, s1_ff.col};
         off[2] = {2'b00, s1_ff.col} + (SIZE_W+1)'(1);
         off[3] = {1'b0, s1_ff.cols} + {2'b00, s1_ff.col} + (SIZE_W+1)'(1);
      end
      for (int s = 0; s < SLOTS; s++) begin
         grp_addr_in[s] = base + ADDR_W'(off[s]);
      end
   end

   always_comb begin
      grp_valid_in = grp_free ? s1_move : grp_valid_ff;
      grp_idx_in   = grp_idx_ff;
      if (s1_move) begin
         grp_idx_in = '0;
      end else if (out_load && grp_valid_ff && !grp_at_last) begin
         grp_idx_in = grp_idx_ff + SLOT_W'(1);
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = out_load ? grp_valid_ff : rsp_valid_ff;
      rsp_pix_in   = rsp_pix_ff;
      rsp_addr_in  = rsp_addr_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_fe_in    = rsp_fe_ff;
      if (out_load && grp_valid_ff) begin
         rsp_pix_in  = grp_pix_ff[grp_idx_ff];
         rsp_addr_in = grp_addr_ff[grp_idx_ff];
         rsp_last_in = grp_at_last;
         rsp_fe_in   = grp_at_last && grp_fe_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_BLOCK_2X2;
         rows_ff      <= ROWS_RESET;
         cols_ff      <= COLS_RESET;
         row_ff       <= '0;
         col_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         grp_valid_ff <= 1'b0;
         grp_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         rows_ff      <= rows_in;
         cols_ff      <= cols_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         s1_valid_ff  <= s1_valid_in;
         grp_valid_ff <= grp_valid_in;
         grp_idx_ff   <= grp_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
      if (s1_move) begin
         grp_last_ff <= grp_last_in;
         grp_fe_ff   <= grp_fe_in;
         for (int s = 0; s < SLOTS; s++) begin
            grp_pix_ff[s]  <= grp_pix_in[s];
            grp_addr_ff[s] <= grp_addr_in[s];
         end
      end
      rsp_pix_ff  <= rsp_pix_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_last_ff <= rsp_last_in;
      rsp_fe_ff   <= rsp_fe_in;
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.pixel_value   = rsp_pix_ff;
   assign rsp_bus.pixel_address = rsp_addr_ff;
   assign rsp_bus.last_of_group = rsp_last_ff;
   assign rsp_bus.frame_end     = rsp_fe_ff;

   a_fe_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_fe_ff |-> rsp_last_ff)
      else $error("frame end on a beat that does not close its group");

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      grp_valid_ff |-> grp_idx_ff <= grp_last_ff)
      else $error("group index beyond last slot");

   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_move |=> s1_valid_ff && $stable(s1_ff))
      else $error("input register lost a stalled group");

   a_grp_load: assert property (@(posedge clock) disable iff (reset)
      s1_move |=> grp_valid_ff && grp_idx_ff == '0)
      else $error("group buffer did not restart on load");

endmodule
